>>> rtl/core/jtfe_pkg.sv
// Package for the JSON top-level field extractor: character codes, scan modes,
// configuration register indexes and the state and result structures.
// Depends on nothing; every other file of the block but jtfe_if uses it.
package jtfe_pkg;

   localparam int KEY_MAX_BYTES = 16;
   localparam int DEPTH_BITS    = 16;
   localparam int KEY_POS_BITS  = $clog2(KEY_MAX_BYTES + 1);
   localparam int KEY_IDX_BITS  = $clog2(KEY_MAX_BYTES);
   localparam int KEY_BITS      = 8 * KEY_MAX_BYTES;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_IDX_BITS  = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_KEY_BYTES_LOW  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KEY_BYTES_HIGH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KEY_LENGTH     = 2'd2;

   localparam logic [63:0]             KEY_BYTES_LOW_RESET  = 64'h0000_0000_6E69_616D;
   localparam logic [63:0]             KEY_BYTES_HIGH_RESET = 64'h0;
   localparam logic [KEY_POS_BITS-1:0] KEY_LENGTH_RESET     = 5'd4;

   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_COLON     = 8'h3A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;

   typedef enum logic [5:0] {
      MODE_SCAN        = 6'b000001,
      MODE_KEYSTR      = 6'b000010,
      MODE_AFTER_KEY   = 6'b000100,
      MODE_AFTER_COLON = 6'b001000,
      MODE_VALUE       = 6'b010000,
      MODE_IDLE        = 6'b100000
   } mode_type;

   typedef struct packed {
      mode_type                mode;
      logic                    escape_pending;
      logic [DEPTH_BITS-1:0]   nesting_depth;
      logic [KEY_POS_BITS-1:0] key_position;
      logic                    key_mismatch;
   } state_type;

   typedef struct packed {
      logic       has_value_byte;
      logic [7:0] value_byte;
      logic       done_res;
      logic       found;
   } result_type;

   localparam state_type STATE_RESET = '{
      mode:           MODE_SCAN,
      escape_pending: 1'b0,
      nesting_depth:  '0,
      key_position:   '0,
      key_mismatch:   1'b0
   };

endpackage

>>> rtl/core/jtfe_if.sv
// Beat channels of the JSON field extractor: text bytes in, results out.
// Depends on no other file; the field widths are written out in the interfaces.
interface jtfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jtfe_rsp_if;
   logic       valid;
   logic       ready;
   logic       has_value_byte;
   logic [7:0] value_byte;
   logic       done_res;
   logic       found;

   modport source (output valid, output has_value_byte, output value_byte,
                   output done_res, output found, input ready);
   modport sink (input valid, input has_value_byte, input value_byte,
                 input done_res, input found, output ready);
endinterface

>>> rtl/core/jtfe_step.sv
// Per-byte scanner logic: next scan state and the optional result for one byte.
// Purely combinational; depends on jtfe_pkg.
module jtfe_step (
   input  jtfe_pkg::state_type                   state_cur,
   input  logic [7:0]                            text_byte,
   input  logic                                  end_of_text,
   input  logic [jtfe_pkg::KEY_BITS-1:0]         key_bytes,
   input  logic [jtfe_pkg::KEY_POS_BITS-1:0]     key_length,
   output jtfe_pkg::state_type                   state_nxt,
   output jtfe_pkg::result_type                  result,
   output logic                                  result_any
);

   logic [jtfe_pkg::KEY_POS_BITS-1:0] key_len_eff;
   logic [7:0]                        key_byte;
   logic                              is_blank;
   logic                              has;
   logic                              done;
   logic                              found;
   logic [7:0]                        vb;

   assign key_len_eff = (key_length > jtfe_pkg::KEY_POS_BITS'(jtfe_pkg::KEY_MAX_BYTES)) ?
                        jtfe_pkg::KEY_POS_BITS'(jtfe_pkg::KEY_MAX_BYTES) : key_length;
   assign key_byte = key_bytes[state_cur.key_position[jtfe_pkg::KEY_IDX_BITS-1:0] * 8 +: 8];
   assign is_blank = (text_byte == jtfe_pkg::CHAR_SPACE) || (text_byte == jtfe_pkg::CHAR_TAB) ||
                     (text_byte == jtfe_pkg::CHAR_LF) || (text_byte == jtfe_pkg::CHAR_CR);

   function automatic jtfe_pkg::state_type scan_byte(input jtfe_pkg::state_type s,
                                                      input logic [7:0] b);
      jtfe_pkg::state_type r;
      r = s;
      if ((b == jtfe_pkg::CHAR_LBRACE) || (b == jtfe_pkg::CHAR_LBRACKET)) begin
         if (s.nesting_depth != '1) begin
            r.nesting_depth = s.nesting_depth + 1'b1;
         end
      end else if ((b == jtfe_pkg::CHAR_RBRACE) || (b == jtfe_pkg::CHAR_RBRACKET)) begin
         if (s.nesting_depth != '0) begin
            r.nesting_depth = s.nesting_depth - 1'b1;
         end
      end else if (b == jtfe_pkg::CHAR_QUOTE) begin
         r.mode           = jtfe_pkg::MODE_KEYSTR;
         r.key_position   = '0;
         r.key_mismatch   = 1'b0;
         r.escape_pending = 1'b0;
      end
      return r;
   endfunction

   function automatic jtfe_pkg::state_type key_feed(input jtfe_pkg::state_type s,
                                                     input logic [7:0] b,
                                                     input logic [7:0] kb,
                                                     input logic [jtfe_pkg::KEY_POS_BITS-1:0] klen);
      jtfe_pkg::state_type r;
      r = s;
      if (s.key_position >= klen) begin
         r.key_mismatch = 1'b1;
      end else begin
         if (b != kb) begin
            r.key_mismatch = 1'b1;
         end
         r.key_position = s.key_position + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      state_nxt  = state_cur;
      has        = 1'b0;
      done       = 1'b0;
      found      = 1'b0;
      vb         = 8'h00;
      result_any = 1'b0;
      unique case (state_cur.mode)
         jtfe_pkg::MODE_SCAN: begin
            state_nxt = scan_byte(state_cur, text_byte);
         end
         jtfe_pkg::MODE_KEYSTR: begin
            if (state_cur.escape_pending) begin
               state_nxt = key_feed(state_cur, text_byte, key_byte, key_len_eff);
               state_nxt.escape_pending = 1'b0;
            end else if (text_byte == jtfe_pkg::CHAR_QUOTE) begin
               if ((state_cur.nesting_depth == jtfe_pkg::DEPTH_BITS'(1)) &&
                   !state_cur.key_mismatch && (state_cur.key_position == key_len_eff)) begin
                  state_nxt.mode = jtfe_pkg::MODE_AFTER_KEY;
               end else begin
                  state_nxt.mode = jtfe_pkg::MODE_SCAN;
               end
            end else begin
               state_nxt = key_feed(state_cur, text_byte, key_byte, key_len_eff);
               if (text_byte == jtfe_pkg::CHAR_BACKSLASH) begin
                  state_nxt.escape_pending = 1'b1;
               end
            end
         end
         jtfe_pkg::MODE_AFTER_KEY: begin
            if (is_blank) begin
               state_nxt = state_cur;
            end else if (text_byte == jtfe_pkg::CHAR_COLON) begin
               state_nxt.mode = jtfe_pkg::MODE_AFTER_COLON;
            end else begin
               state_nxt = scan_byte(state_cur, text_byte);
               if (text_byte != jtfe_pkg::CHAR_QUOTE) begin
                  state_nxt.mode = jtfe_pkg::MODE_SCAN;
               end
            end
         end
         jtfe_pkg::MODE_AFTER_COLON: begin
            if (is_blank) begin
               state_nxt = state_cur;
            end else if (text_byte == jtfe_pkg::CHAR_QUOTE) begin
               state_nxt.mode           = jtfe_pkg::MODE_VALUE;
               state_nxt.escape_pending = 1'b0;
            end else begin
               result_any     = 1'b1;
               done           = 1'b1;
               state_nxt.mode = jtfe_pkg::MODE_IDLE;
            end
         end
         jtfe_pkg::MODE_VALUE: begin
            result_any = 1'b1;
            if (state_cur.escape_pending) begin
               state_nxt.escape_pending = 1'b0;
               has = 1'b1;
               vb  = text_byte;
            end else if (text_byte == jtfe_pkg::CHAR_QUOTE) begin
               done           = 1'b1;
               found          = 1'b1;
               state_nxt.mode = jtfe_pkg::MODE_IDLE;
            end else begin
               if (text_byte == jtfe_pkg::CHAR_BACKSLASH) begin
                  state_nxt.escape_pending = 1'b1;
               end
               has = 1'b1;
               vb  = text_byte;
            end
         end
         jtfe_pkg::MODE_IDLE: begin
            state_nxt = state_cur;
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase

      if (end_of_text) begin
         if (!done) begin
            if (state_nxt.mode == jtfe_pkg::MODE_VALUE) begin
               result_any = 1'b1;
               done       = 1'b1;
               found      = 1'b1;
            end else if (state_nxt.mode != jtfe_pkg::MODE_IDLE) begin
               result_any = 1'b1;
               done       = 1'b1;
               found      = 1'b0;
            end
         end
         state_nxt = jtfe_pkg::STATE_RESET;
      end

      result.has_value_byte = has;
      result.value_byte     = vb;
      result.done_res       = done;
      result.found          = done && found;
   end

endmodule

>>> rtl/core/jtfe_out_reg.sv
// Result register of the field extractor: holds one result beat until taken.
// Depends on jtfe_pkg and the jtfe_rsp_if channel.
module jtfe_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  jtfe_pkg::result_type result,
   output logic                 out_free,
   jtfe_rsp_if.source           rsp_bus
);

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   jtfe_pkg::result_type rsp_data_ff;

   assign out_free     = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_valid_in = load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.has_value_byte = rsp_data_ff.has_value_byte;
   assign rsp_bus.value_byte     = rsp_data_ff.value_byte;
   assign rsp_bus.done_res       = rsp_data_ff.done_res;
   assign rsp_bus.found          = rsp_data_ff.found;

endmodule

>>> rtl/core/json_top_level_field_extractor.sv
// JSON top-level field extractor: streams the string value of a configured key.
// Each accepted beat is held in the s1 stage register; its result, if any, is loaded into
// the result register when that stage advances.
// Throughput: one text byte per cycle unless a byte's result waits for a full result register.
// Reset: synchronous, clears the scan state and loads the key registers' defaults.
// Depends on jtfe_pkg, jtfe_if, jtfe_step and jtfe_out_reg.
module json_top_level_field_extractor (
   input  logic                                clock,
   input  logic                                reset,
   jtfe_req_if.sink                            req_bus,
   jtfe_rsp_if.source                          rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [jtfe_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [jtfe_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   logic                               s1_valid_ff;
   logic                               s1_valid_in;
   logic [7:0]                         s1_byte_ff;
   logic                               s1_eot_ff;
   logic                               req_accept;
   logic                               advance;
   logic                               out_free;
   logic                               step_any;
   jtfe_pkg::state_type                state_ff;
   jtfe_pkg::state_type                state_nxt;
   jtfe_pkg::result_type               step_result;
   logic [63:0]                        key_bytes_low_ff;
   logic [63:0]                        key_bytes_high_ff;
   logic [jtfe_pkg::KEY_POS_BITS-1:0]  key_length_ff;

   assign advance       = s1_valid_ff && (!step_any || out_free);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign s1_valid_in   = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_bus.text_byte;
         s1_eot_ff  <= req_bus.end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jtfe_pkg::STATE_RESET;
      end else if (advance) begin
         state_ff <= state_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_low_ff  <= jtfe_pkg::KEY_BYTES_LOW_RESET;
         key_bytes_high_ff <= jtfe_pkg::KEY_BYTES_HIGH_RESET;
         key_length_ff     <= jtfe_pkg::KEY_LENGTH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            jtfe_pkg::CSR_KEY_BYTES_LOW: begin
               key_bytes_low_ff <= csr_write_data;
            end
            jtfe_pkg::CSR_KEY_BYTES_HIGH: begin
               key_bytes_high_ff <= csr_write_data;
            end
            jtfe_pkg::CSR_KEY_LENGTH: begin
               key_length_ff <= csr_write_data[jtfe_pkg::KEY_POS_BITS-1:0];
            end
            default: begin
               key_length_ff <= key_length_ff;
            end
         endcase
      end
   end

   jtfe_step u_step (
      .state_cur   (state_ff),
      .text_byte   (s1_byte_ff),
      .end_of_text (s1_eot_ff),
      .key_bytes   ({key_bytes_high_ff, key_bytes_low_ff}),
      .key_length  (key_length_ff),
      .state_nxt   (state_nxt),
      .result      (step_result),
      .result_any  (step_any)
   );

   jtfe_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && step_any),
      .result   (step_result),
      .out_free (out_free),
      .rsp_bus  (rsp_bus)
   );

`ifndef SYNTHESIS
   a_eot_rearms: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_eot_ff) |=>
      (state_ff.mode == jtfe_pkg::MODE_SCAN) && (state_ff.nesting_depth == '0))
      else $error("scan state not cleared after the last byte of a document");

   a_eot_reports: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_eot_ff && (state_ff.mode != jtfe_pkg::MODE_IDLE)) |->
      (step_any && step_result.done_res))
      else $error("document ended without a done beat");

   a_found_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (!rsp_bus.found || rsp_bus.done_res))
      else $error("found reported without done");

   a_stall_holds_byte: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_byte_ff) && $stable(state_ff)))
      else $error("held byte or scan state changed during a stall");

   a_no_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.has_value_byte) |-> (rsp_bus.value_byte == 8'h00))
      else $error("value byte nonzero on a beat without a value byte");
`endif

endmodule

>>> bench/json_top_level_field_extractor_test.sv
`timescale 1ns / 1ps
// Self-checking bench for json_top_level_field_extractor: streams JSON documents
// through the request channel and checks every response beat against a local model.
// Depends on jtfe_pkg, the jtfe_req_if and jtfe_rsp_if channels and the block itself.
module json_top_level_field_extractor_test;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [7:0] CHAR_COMMA      = 8'h2C;
   localparam logic [7:0] CHAR_DIGIT_ZERO = 8'h30;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } text_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable;
   logic [jtfe_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [jtfe_pkg::CSR_DATA_BITS-1:0] csr_write_data;

   jtfe_req_if req_ch ();
   jtfe_rsp_if rsp_ch ();

   json_top_level_field_extractor DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_ch),
      .rsp_bus          (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   text_beat_type        pending_text[$];
   jtfe_pkg::result_type expected_results[$];
   logic [7:0]           draft_doc[$];

   // Local copy of the scanner state and the key registers.
   jtfe_pkg::mode_type                scan_mode_q;
   logic                              escape_q;
   logic [jtfe_pkg::DEPTH_BITS-1:0]   depth_q;
   logic [jtfe_pkg::KEY_POS_BITS-1:0] key_pos_q;
   logic                              mismatch_q;
   logic [63:0]                       key_low_q;
   logic [63:0]                       key_high_q;
   logic [4:0]                        key_len_q;

   bit steady_flow = 1'b0;
   int send_gap = 0;
   int hold_cycles = 0;
   int idle_count = 0;
   int mismatch_count = 0;
   int beat_count = 0;
   int result_count = 0;
   int found_count = 0;
   int doc_count = 0;
   int setting_count = 1;

   function automatic int used_key_length();
      if (key_len_q > jtfe_pkg::KEY_MAX_BYTES) return jtfe_pkg::KEY_MAX_BYTES;
      return key_len_q;
   endfunction

   function automatic logic [7:0] key_byte_at(input int idx);
      if (idx < 8) return key_low_q[8*idx +: 8];
      return key_high_q[8*(idx-8) +: 8];
   endfunction

   function automatic bit is_blank(input logic [7:0] b);
      return b == jtfe_pkg::CHAR_SPACE || b == jtfe_pkg::CHAR_TAB ||
             b == jtfe_pkg::CHAR_LF || b == jtfe_pkg::CHAR_CR;
   endfunction

   function automatic void clear_scan_state();
      scan_mode_q = jtfe_pkg::MODE_SCAN;
      escape_q    = 1'b0;
      depth_q     = '0;
      key_pos_q   = '0;
      mismatch_q  = 1'b0;
   endfunction

   function automatic void scan_outside(input logic [7:0] b);
      if (b == jtfe_pkg::CHAR_LBRACE || b == jtfe_pkg::CHAR_LBRACKET) begin
         if (depth_q != {jtfe_pkg::DEPTH_BITS{1'b1}}) depth_q = depth_q + 1'b1;
      end else if (b == jtfe_pkg::CHAR_RBRACE || b == jtfe_pkg::CHAR_RBRACKET) begin
         if (depth_q != '0) depth_q = depth_q - 1'b1;
      end else if (b == jtfe_pkg::CHAR_QUOTE) begin
         scan_mode_q = jtfe_pkg::MODE_KEYSTR;
         key_pos_q   = '0;
         mismatch_q  = 1'b0;
         escape_q    = 1'b0;
      end
   endfunction

   function automatic void feed_key(input logic [7:0] b);
      if (key_pos_q >= used_key_length()) begin
         mismatch_q = 1'b1;
      end else begin
         if (b != key_byte_at(key_pos_q)) mismatch_q = 1'b1;
         key_pos_q = key_pos_q + 1'b1;
      end
   endfunction

   function automatic bit predict_result(input logic [7:0] b, input logic eot,
                                         output jtfe_pkg::result_type r);
      bit emit;
      emit = 1'b0;
      r = '0;
      case (scan_mode_q)
         jtfe_pkg::MODE_SCAN: scan_outside(b);
         jtfe_pkg::MODE_KEYSTR: begin
            if (escape_q) begin
               escape_q = 1'b0;
               feed_key(b);
            end else if (b == jtfe_pkg::CHAR_QUOTE) begin
               if (depth_q == 1 && !mismatch_q && key_pos_q == used_key_length())
                  scan_mode_q = jtfe_pkg::MODE_AFTER_KEY;
               else
                  scan_mode_q = jtfe_pkg::MODE_SCAN;
            end else begin
               if (b == jtfe_pkg::CHAR_BACKSLASH) escape_q = 1'b1;
               feed_key(b);
            end
         end
         jtfe_pkg::MODE_AFTER_KEY: begin
            if (b == jtfe_pkg::CHAR_COLON) begin
               scan_mode_q = jtfe_pkg::MODE_AFTER_COLON;
            end else if (!is_blank(b)) begin
               scan_mode_q = jtfe_pkg::MODE_SCAN;
               scan_outside(b);
            end
         end
         jtfe_pkg::MODE_AFTER_COLON: begin
            if (b == jtfe_pkg::CHAR_QUOTE) begin
               scan_mode_q = jtfe_pkg::MODE_VALUE;
               escape_q    = 1'b0;
            end else if (!is_blank(b)) begin
               emit        = 1'b1;
               r.done_res  = 1'b1;
               scan_mode_q = jtfe_pkg::MODE_IDLE;
            end
         end
         jtfe_pkg::MODE_VALUE: begin
            emit = 1'b1;
            if (escape_q) begin
               escape_q         = 1'b0;
               r.has_value_byte = 1'b1;
               r.value_byte     = b;
            end else if (b == jtfe_pkg::CHAR_QUOTE) begin
               r.done_res  = 1'b1;
               r.found     = 1'b1;
               scan_mode_q = jtfe_pkg::MODE_IDLE;
            end else begin
               if (b == jtfe_pkg::CHAR_BACKSLASH) escape_q = 1'b1;
               r.has_value_byte = 1'b1;
               r.value_byte     = b;
            end
         end
         default: ;
      endcase
      if (eot) begin
         if (!r.done_res) begin
            if (scan_mode_q == jtfe_pkg::MODE_VALUE) begin
               emit       = 1'b1;
               r.done_res = 1'b1;
               r.found    = 1'b1;
            end else if (scan_mode_q != jtfe_pkg::MODE_IDLE) begin
               emit       = 1'b1;
               r.done_res = 1'b1;
            end
         end
         clear_scan_state();
      end
      return emit;
   endfunction

   function automatic int idle_length();
      int pick;
      if (steady_flow) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatch_count++;
      $display("mismatch at response %0d: %s got %0h expected %0h",
               result_count, what, got, want);
   endtask

   always @(posedge clock) begin : driver
      text_beat_type        beat;
      jtfe_pkg::result_type predicted;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            beat_count++;
            if (predict_result(req_ch.text_byte, req_ch.end_of_text, predicted))
               expected_results.push_back(predicted);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_text.size() != 0) begin
               beat = pending_text.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.text_byte   <= beat.text_byte;
               req_ch.end_of_text <= beat.end_of_text;
               send_gap = idle_length();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      jtfe_pkg::result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            result_count++;
            if (rsp_ch.done_res && rsp_ch.found) found_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected beat, value_byte", rsp_ch.value_byte, 8'h00);
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.has_value_byte !== want.has_value_byte)
                  report_mismatch("has_value_byte", 8'(rsp_ch.has_value_byte),
                                  8'(want.has_value_byte));
               if (rsp_ch.value_byte !== want.value_byte)
                  report_mismatch("value_byte", rsp_ch.value_byte, want.value_byte);
               if (rsp_ch.done_res !== want.done_res)
                  report_mismatch("done_res", 8'(rsp_ch.done_res), 8'(want.done_res));
               if (rsp_ch.found !== want.found)
                  report_mismatch("found", 8'(rsp_ch.found), 8'(want.found));
            end
            hold_cycles = idle_length();
         end else if (rsp_ch.ready && $urandom_range(0, 15) == 0) begin
            hold_cycles = idle_length();
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || csr_write_enable) begin
         idle_count = 0;
      end else begin
         idle_count++;
         if (idle_count == WATCHDOG_LIMIT) begin
            $display("no beat moved for %0d cycles, %0d responses outstanding",
                     WATCHDOG_LIMIT, expected_results.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 3))
         0: return jtfe_pkg::CHAR_SPACE;
         1: return jtfe_pkg::CHAR_TAB;
         2: return jtfe_pkg::CHAR_LF;
         default: return jtfe_pkg::CHAR_CR;
      endcase
   endfunction

   function automatic logic [63:0] random_letters();
      logic [63:0] word;
      for (int i = 0; i < 8; i++) word[8*i +: 8] = 8'($urandom_range(8'h61, 8'h7A));
      return word;
   endfunction

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) draft_doc.push_back(s[i]);
   endtask

   task automatic append_key();
      for (int i = 0; i < used_key_length(); i++) draft_doc.push_back(key_byte_at(i));
   endtask

   task automatic append_string_body(input int units);
      repeat (units) begin
         case ($urandom_range(0, 9))
            0: begin
               draft_doc.push_back(jtfe_pkg::CHAR_BACKSLASH);
               draft_doc.push_back(8'($urandom_range(0, 255)));
            end
            1: draft_doc.push_back(8'($urandom_range(0, 255)));
            default: draft_doc.push_back(8'($urandom_range(8'h20, 8'h7E)));
         endcase
      end
   endtask

   task automatic queue_document();
      text_beat_type beat;
      foreach (draft_doc[i]) begin
         beat.text_byte   = draft_doc[i];
         beat.end_of_text = (i == draft_doc.size() - 1);
         pending_text.push_back(beat);
      end
      draft_doc.delete();
      doc_count++;
   endtask

   task automatic queue_random_text(input int budget);
      int sent, members, pick, klen, pos;
      sent = 0;
      klen = used_key_length();
      while (sent < budget) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) draft_doc.push_back(8'($urandom_range(0, 255)));
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0) draft_doc.push_back(jtfe_pkg::CHAR_LBRACKET);
            else if (pick == 1) draft_doc.push_back(jtfe_pkg::CHAR_RBRACE);
            if (pick != 2) draft_doc.push_back(jtfe_pkg::CHAR_LBRACE);
            members = $urandom_range(1, 3);
            for (int m = 0; m < members; m++) begin
               if (m > 0) draft_doc.push_back(CHAR_COMMA);
               draft_doc.push_back(jtfe_pkg::CHAR_QUOTE);
               pick = $urandom_range(0, 7);
               if (pick < 6) begin
                  append_key();
                  if (pick == 3 && klen > 0) begin
                     pos = draft_doc.size() - klen + $urandom_range(0, klen - 1);
                     draft_doc[pos] = draft_doc[pos] ^ 8'(1 << $urandom_range(0, 7));
                  end else if (pick == 4) begin
                     draft_doc.push_back(8'($urandom_range(8'h61, 8'h7A)));
                  end else if (pick == 5 && klen > 0) begin
                     void'(draft_doc.pop_back());
                  end
               end else begin
                  append_string_body($urandom_range(0, 4));
               end
               draft_doc.push_back(jtfe_pkg::CHAR_QUOTE);
               repeat ($urandom_range(0, 2)) draft_doc.push_back(blank_byte());
               if ($urandom_range(0, 7) != 0)
                  draft_doc.push_back(jtfe_pkg::CHAR_COLON);
               else
                  draft_doc.push_back($urandom_range(0, 1) ? jtfe_pkg::CHAR_LBRACE : 8'h78);
               repeat ($urandom_range(0, 2)) draft_doc.push_back(blank_byte());
               pick = $urandom_range(0, 7);
               if (pick < 4) begin
                  draft_doc.push_back(jtfe_pkg::CHAR_QUOTE);
                  append_string_body($urandom_range(0, 5));
                  draft_doc.push_back(jtfe_pkg::CHAR_QUOTE);
               end else if (pick == 4) begin
                  repeat ($urandom_range(1, 3))
                     draft_doc.push_back(CHAR_DIGIT_ZERO + 8'($urandom_range(0, 9)));
               end else if (pick == 5) begin
                  draft_doc.push_back(jtfe_pkg::CHAR_LBRACE);
                  draft_doc.push_back(jtfe_pkg::CHAR_QUOTE);
                  append_key();
                  append_text("\":\"z\"");
                  draft_doc.push_back(jtfe_pkg::CHAR_RBRACE);
               end else if (pick == 6) begin
                  append_text("[\"q\"]");
               end else begin
                  append_text("true");
               end
            end
            if ($urandom_range(0, 3) != 0) draft_doc.push_back(jtfe_pkg::CHAR_RBRACE);
            if ($urandom_range(0, 3) == 0) begin
               pos = $urandom_range(1, draft_doc.size());
               while (draft_doc.size() > pos) void'(draft_doc.pop_back());
            end
         end
         sent += draft_doc.size();
         queue_document();
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_text.size() != 0 || req_ch.valid || expected_results.size() != 0);
   endtask

   task automatic write_csr(input logic [jtfe_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [63:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         jtfe_pkg::CSR_KEY_BYTES_LOW:  key_low_q  = data;
         jtfe_pkg::CSR_KEY_BYTES_HIGH: key_high_q = data;
         jtfe_pkg::CSR_KEY_LENGTH:     key_len_q  = data[4:0];
         default: ;
      endcase
   endtask

   task automatic load_key(input logic [63:0] low, input logic [63:0] high,
                           input logic [63:0] length);
      wait_idle();
      repeat (4) @(posedge clock);
      write_csr(jtfe_pkg::CSR_KEY_BYTES_LOW, low);
      write_csr(jtfe_pkg::CSR_KEY_BYTES_HIGH, high);
      write_csr(jtfe_pkg::CSR_KEY_LENGTH, length);
      @(negedge clock);
      steady_flow = ($urandom_range(0, 3) == 0);
      setting_count++;
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.text_byte   = 8'h00;
      req_ch.end_of_text = 1'b0;
      rsp_ch.ready       = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = jtfe_pkg::CSR_KEY_BYTES_LOW;
      csr_write_data     = '0;
      key_low_q  = jtfe_pkg::KEY_BYTES_LOW_RESET;
      key_high_q = jtfe_pkg::KEY_BYTES_HIGH_RESET;
      key_len_q  = jtfe_pkg::KEY_LENGTH_RESET;
      clear_scan_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default key: escaped quote in the value, no key, and single-byte documents.
      append_text("{\"main\":\"a\\\"\"}");
      queue_document();
      append_text("[1]");
      queue_document();
      draft_doc.push_back(8'h00);
      queue_document();
      draft_doc.push_back(8'hFF);
      queue_document();
      queue_random_text(80);

      load_key(64'h0, 64'h0, 64'd0);
      append_text("{\"\":5}");
      queue_document();
      queue_random_text(50);

      load_key(64'h6469, 64'h0, 64'd2);
      queue_random_text(70);
      load_key(64'h6222_5C61, 64'h0, 64'd4);
      queue_random_text(60);
      load_key(random_letters(), random_letters(), 64'd31);
      queue_random_text(70);
      load_key({64{1'b1}}, {64{1'b1}}, 64'd16);
      queue_random_text(40);
      load_key(64'h0, 64'h0, 64'd16);
      queue_random_text(40);
      repeat (3) begin
         load_key(random_letters(), random_letters(),
                  64'($urandom_range(1, jtfe_pkg::KEY_MAX_BYTES)));
         queue_random_text(40);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("ran %0d documents (%0d text beats) over %0d key settings", doc_count,
               beat_count, setting_count);
      $display("checked %0d response beats, %0d values found, %0d mismatches", result_count,
               found_count, mismatch_count);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
